@@ src/acge_pkg.sv @@
`timescale 1ns / 1ps

package acge_pkg;

    // Fixed-point gain constants, Q1.23
    localparam int unsigned GAIN_W = 24;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h800000;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 24'hFFFFFF;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned FRAC_W   = 23;
    localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCED_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd6;

    // Reset values of the configuration registers
    localparam logic [31:0]       RST_THRESHOLD     = 32'd214748365;
    localparam logic [GAIN_W-1:0] RST_REDUCED_GAIN  = 24'd4194304;
    localparam logic [TICK_W-1:0] RST_ATTACK_TICKS  = 16'd3000;
    localparam logic [TICK_W-1:0] RST_RELEASE_TICKS = 16'd2000;
    localparam logic [TICK_W-1:0] RST_HOLD_TICKS    = 16'd1000;
    localparam logic [GAIN_W-1:0] RST_ATTACK_STEP   = 24'd1398;
    localparam logic [GAIN_W-1:0] RST_RELEASE_STEP  = 24'd2097;

    // Request queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef struct packed {
        logic [31:0]       threshold;
        logic [GAIN_W-1:0] reduced_gain;
        logic [TICK_W-1:0] attack_ticks;
        logic [TICK_W-1:0] release_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [GAIN_W-1:0] attack_step;
        logic [GAIN_W-1:0] release_step;
    } cfg_t;

    // Classified request: sign, magnitude and threshold outcome
    typedef struct packed {
        logic                neg;
        logic [SAMPLE_W-1:0] mag;
        logic                above;
        logic                below;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ATTACK  = 4'b0010,
        ST_HOLD    = 4'b0100,
        ST_RELEASE = 4'b1000
    } env_state_t;

endpackage

@@ src/acge_cfg.sv @@
`timescale 1ns / 1ps

module acge_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    output acge_pkg::cfg_t                  cfg
);
    import acge_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register file, writes masked to register width, unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold     <= RST_THRESHOLD;
            cfg_reg.reduced_gain  <= RST_REDUCED_GAIN;
            cfg_reg.attack_ticks  <= RST_ATTACK_TICKS;
            cfg_reg.release_ticks <= RST_RELEASE_TICKS;
            cfg_reg.hold_ticks    <= RST_HOLD_TICKS;
            cfg_reg.attack_step   <= RST_ATTACK_STEP;
            cfg_reg.release_step  <= RST_RELEASE_STEP;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD:     cfg_reg.threshold     <= cfg_data;
                REG_REDUCED_GAIN:  cfg_reg.reduced_gain  <= cfg_data[GAIN_W-1:0];
                REG_ATTACK_TICKS:  cfg_reg.attack_ticks  <= cfg_data[TICK_W-1:0];
                REG_RELEASE_TICKS: cfg_reg.release_ticks <= cfg_data[TICK_W-1:0];
                REG_HOLD_TICKS:    cfg_reg.hold_ticks    <= cfg_data[TICK_W-1:0];
                REG_ATTACK_STEP:   cfg_reg.attack_step   <= cfg_data[GAIN_W-1:0];
                REG_RELEASE_STEP:  cfg_reg.release_step  <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ src/acge_front.sv @@
`timescale 1ns / 1ps

module acge_front (
    input  logic [acge_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [31:0]                   threshold,
    output acge_pkg::item_t               item
);
    import acge_pkg::*;

    logic                neg;
    logic [SAMPLE_W-1:0] mag;

    // Magnitude; the most negative sample wraps to exactly 2^31 unsigned
    assign neg = sample_in[SAMPLE_W-1];
    assign mag = neg ? (~sample_in + 32'd1) : sample_in;

    // Classify against the threshold
    assign item.neg   = neg;
    assign item.mag   = mag;
    assign item.above = (mag > threshold);
    assign item.below = (mag < threshold);

endmodule

@@ src/acge_fifo.sv @@
`timescale 1ns / 1ps

module acge_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  acge_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output acge_pkg::item_t out_item
);
    import acge_pkg::*;

    item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("request queue over capacity");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("request queue pointers out of step with count");

    a_pop_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("request queue popped while empty");
`endif

endmodule

@@ src/acge_back.sv @@
`timescale 1ns / 1ps

module acge_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  acge_pkg::cfg_t                cfg,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  acge_pkg::item_t               item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [acge_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic [acge_pkg::GAIN_W-1:0]   m_gain_now
);
    import acge_pkg::*;

    env_state_t        mode_reg, mode_next, mode_mid;
    logic [TICK_W-1:0] cnt_reg, cnt_next, cnt_mid;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [GAIN_W:0]   rel_sum;

    logic                p1_valid_reg;
    logic                p1_neg_reg;
    logic [SAMPLE_W-1:0] p1_mag_reg;
    logic [GAIN_W-1:0]   p1_gain_reg;

    logic                p2_valid_reg;
    logic                p2_neg_reg;
    logic [PROD_W-1:0]   p2_prod_reg;
    logic [GAIN_W-1:0]   p2_gain_reg;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_sample_reg;
    logic [GAIN_W-1:0]   m_gain_reg;

    logic                adv;
    logic                pop;
    logic [SAMPLE_W:0]   q_shift;
    logic [SAMPLE_W-1:0] sat_out;

    // Whole back pipeline moves together when the output slot frees up
    assign adv     = !m_valid_reg || m_ready;
    assign q_ready = adv;
    assign pop     = q_valid && adv;

    // Envelope: threshold events first, then one step of the ramp
    always_comb begin
        mode_mid = mode_reg;
        cnt_mid  = cnt_reg;
        if (item.above) begin
            if (gain_reg >= cfg.reduced_gain &&
                (mode_reg == ST_IDLE || mode_reg == ST_RELEASE)) begin
                mode_mid = ST_ATTACK;
                cnt_mid  = cfg.attack_ticks;
            end
            if (mode_mid == ST_HOLD) begin
                cnt_mid = cfg.hold_ticks;
            end
        end
        if (item.below && gain_reg <= UNITY_GAIN &&
            cnt_mid == '0 && mode_mid == ST_HOLD) begin
            mode_mid = ST_RELEASE;
            cnt_mid  = cfg.release_ticks;
        end

        mode_next = mode_mid;
        cnt_next  = cnt_mid;
        gain_next = gain_reg;
        rel_sum   = {1'b0, gain_reg} + {1'b0, cfg.release_step};
        case (mode_mid)
            ST_ATTACK: begin
                if (cnt_mid != '0 && gain_reg > cfg.reduced_gain) begin
                    gain_next = (gain_reg > cfg.attack_step) ?
                                (gain_reg - cfg.attack_step) : '0;
                    cnt_next  = cnt_mid - 1'b1;
                end else begin
                    mode_next = ST_HOLD;
                    cnt_next  = cfg.hold_ticks;
                end
            end
            ST_HOLD: begin
                if (cnt_mid != '0) begin
                    cnt_next = cnt_mid - 1'b1;
                end else begin
                    mode_next = ST_RELEASE;
                    cnt_next  = cfg.release_ticks;
                end
            end
            ST_RELEASE: begin
                if (cnt_mid != '0 && gain_reg < UNITY_GAIN) begin
                    cnt_next  = cnt_mid - 1'b1;
                    gain_next = rel_sum[GAIN_W] ? GAIN_MAX : rel_sum[GAIN_W-1:0];
                end else begin
                    mode_next = ST_IDLE;
                end
            end
            default: begin
                // idle only lifts a gain that sits below unity
                if (gain_reg < UNITY_GAIN) begin
                    gain_next = UNITY_GAIN;
                end
            end
        endcase
    end

    // Envelope state, advanced once per popped request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ST_IDLE;
            cnt_reg  <= '0;
            gain_reg <= UNITY_GAIN;
        end else if (pop) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            gain_reg <= gain_next;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= pop;
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= p2_valid_reg;
        end
    end

    // Stage 1: sample with its updated gain
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_neg_reg  <= item.neg;
            p1_mag_reg  <= item.mag;
            p1_gain_reg <= gain_next;
        end
    end

    // Stage 2: unsigned magnitude times gain
    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_neg_reg  <= p1_neg_reg;
            p2_gain_reg <= p1_gain_reg;
            p2_prod_reg <= PROD_W'(p1_mag_reg) * PROD_W'(p1_gain_reg);
        end
    end

    // Stage 3: drop fraction (toward zero), saturate, restore sign
    assign q_shift = p2_prod_reg[PROD_W-1:FRAC_W];

    always_comb begin
        if (p2_neg_reg) begin
            sat_out = (q_shift > 33'h080000000) ? 32'h80000000
                                                : (~q_shift[SAMPLE_W-1:0] + 32'd1);
        end else begin
            sat_out = (q_shift > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q_shift[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_sample_reg <= sat_out;
            m_gain_reg   <= p2_gain_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_gain_now   = m_gain_reg;

`ifndef SYNTHESIS
    a_stall_holds_env: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(gain_reg) && $stable(cnt_reg)
                                       && $stable(m_sample_reg)))
        else $error("envelope or result moved during output stall");

    a_pipe_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_valid_reg && adv) |=> m_valid_reg)
        else $error("request lost between multiply and output stage");

    a_gain_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (p1_valid_reg && p1_gain_reg == gain_reg))
        else $error("stage 1 gain differs from envelope gain");
`endif

endmodule

@@ src/audio_compressor_gain_envelope.sv @@
`timescale 1ns / 1ps
// Channel   | Ports                                  | Direction
// ----------+----------------------------------------+----------
// sample in | s_valid s_ready s_sample_in            | in
// result    | m_valid m_ready m_sample_out m_gain_now| out
// config    | cfg_valid cfg_ready cfg_index cfg_data | in
//
// One request per cycle sustained while the output is not stalled; the envelope
// update (gain step and tick countdown) is a single registered loop in the back end.
// After a sample is accepted, its result passes in order through the queue,
// envelope/gain, multiply and saturate-to-output registers.
// Reset (aresetn low, synchronous): envelope idle at unity gain, registers
// to defaults, queue empty. Config writes are always ready.
// An output stall freezes the back end; the two-entry queue keeps s_ready up
// until it fills.

module audio_compressor_gain_envelope (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [acge_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [acge_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic [acge_pkg::GAIN_W-1:0]     m_gain_now
);
    import acge_pkg::*;

    cfg_t                cfg;
    item_t               front_item;
    item_t               q_item;
    logic                q_valid;
    logic                q_ready;
    logic [SAMPLE_W-1:0] sample_out;

    acge_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    acge_front u_front (
        .sample_in (s_sample_in),
        .threshold (cfg.threshold),
        .item      (front_item)
    );

    acge_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    acge_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .item         (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (sample_out),
        .m_gain_now   (m_gain_now)
    );

    assign m_sample_out = sample_out;

endmodule
